FILE: rtl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg: shared definitions of the text console writer
// Screen geometry, field widths, command codes and the structs that travel
// between the front end, the command queue and the execution back end.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

  // Screen geometry.
  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int MOVE_COUNT = CELL_COUNT - COLUMNS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);

  // Field widths fixed by the stream payload.
  localparam int CHAR_W  = 8;
  localparam int COORD_W = 8;
  localparam int COL_W   = 7;
  localparam int ROW_W   = 5;
  localparam int CELL_W  = 16;
  localparam int COLOR_W = 4;
  localparam int MODE_W  = 2;

  // Command queue depth, a power of two.
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  // Character codes and cell values.
  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
  localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;
  localparam logic [CELL_W-1:0] RESET_CELL   = 16'h0820;

  // Input mode codes.
  localparam logic [MODE_W-1:0] MODE_PUT   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SET   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd3;

  // Configuration register indexes.
  localparam int                CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_FG = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BG = 1'd1;

  typedef enum logic [2:0] {
    OP_PUT,
    OP_NEWLINE,
    OP_CLEAR,
    OP_SET,
    OP_READ
  } op_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_SCROLL,
    ST_BLANK,
    ST_FINISH
  } state_e;

  // Decoded command held in the queue; coordinates are already clamped.
  typedef struct packed {
    op_e               op;
    logic [CHAR_W-1:0] ch;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
  } cmd_t;

  // Result beat, last field in the lowest bits.
  typedef struct packed {
    logic              scrolled;
    logic [CELL_W-1:0] cell_data;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
  } res_t;

endpackage

`default_nettype wire

FILE: rtl/tcw_ram.sv
// ----------------------------------------------------------------------------
// tcw_ram: generic simple dual-port RAM
// One write port and one read port with registered read data that holds
// its value until the next read.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  wire                      clk_i,
  input  wire                      we_i,
  input  wire  [$clog2(DEPTH)-1:0] waddr_i,
  input  wire  [WIDTH-1:0]         wdata_i,
  input  wire                      re_i,
  input  wire  [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/tcw_front.sv
// ----------------------------------------------------------------------------
// tcw_front: input stage and command queue
// Accepts input beats, decodes the mode, clamps coordinates and holds the
// decoded commands in a short queue for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_front (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          s_axis_tvalid,
  output logic                         s_axis_tready,
  input  wire  [23:0]                  s_axis_tdata,
  input  wire  [tcw_pkg::MODE_W-1:0]   s_axis_tuser,
  input  wire                          busy_i,
  output logic                         cmd_valid_o,
  output tcw_pkg::cmd_t                cmd_o,
  input  wire                          cmd_pop_i
);
  import tcw_pkg::*;

  cmd_t              entry_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              push;
  logic              pop;
  cmd_t              dec;

  logic [CHAR_W-1:0]  in_ch;
  logic [COORD_W-1:0] in_col;
  logic [COORD_W-1:0] in_row;

  assign in_ch  = s_axis_tdata[7:0];
  assign in_col = s_axis_tdata[15:8];
  assign in_row = s_axis_tdata[23:16];

  always_comb begin
    dec.ch  = in_ch;
    dec.col = (in_col >= COORD_W'(COLUMNS)) ? COL_W'(COLUMNS - 1) : in_col[COL_W-1:0];
    dec.row = (in_row >= COORD_W'(ROWS)) ? ROW_W'(ROWS - 1) : in_row[ROW_W-1:0];
    case (s_axis_tuser)
      MODE_PUT:   dec.op = (in_ch == NEWLINE_CODE) ? OP_NEWLINE : OP_PUT;
      MODE_CLEAR: dec.op = OP_CLEAR;
      MODE_SET:   dec.op = OP_SET;
      MODE_READ:  dec.op = OP_READ;
      default:    dec.op = OP_READ;
    endcase
  end

  // No input is taken while the screen store is being initialized.
  assign s_axis_tready = (count_q != QCNT_W'(QDEPTH)) && !busy_i;
  assign push          = s_axis_tvalid && s_axis_tready;
  assign pop           = cmd_pop_i && (count_q != '0);

  assign cmd_valid_o = (count_q != '0);
  assign cmd_o       = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= dec;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/tcw_back.sv
// ----------------------------------------------------------------------------
// tcw_back: command execution
// Owns the screen store, the cursor and the color registers, runs the
// initialization, clear and scroll sweeps and drives the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_back (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            cfg_we_i,
  input  wire  [tcw_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire  [tcw_pkg::COLOR_W-1:0]    cfg_wdata_i,
  input  wire                            cmd_valid_i,
  input  tcw_pkg::cmd_t                  cmd_i,
  output logic                           cmd_pop_o,
  output logic                           busy_o,
  output logic                           res_valid_o,
  input  wire                            res_ready_i,
  output tcw_pkg::res_t                  res_o
);
  import tcw_pkg::*;

  state_e             state_q, state_d;
  logic [ADDR_W-1:0]  cnt_q, cnt_d;
  logic [COL_W-1:0]   cur_x_q, cur_x_d;
  logic [ROW_W-1:0]   cur_y_q, cur_y_d;
  logic               scr_q, scr_d;
  logic               rdf_q, rdf_d;
  logic [COLOR_W-1:0] fg_q, bg_q;
  logic               out_valid_q, out_valid_d;
  res_t               out_q, out_d;

  logic               out_free;
  logic               start;
  logic               last_col;
  logic               last_row;
  logic [ADDR_W-1:0]  cur_addr;
  logic [ADDR_W-1:0]  cmd_addr;
  logic [CELL_W-1:0]  blank;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [CELL_W-1:0]  ram_wdata;
  logic               ram_re;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [CELL_W-1:0]  ram_rdata;

  assign out_free = !out_valid_q || res_ready_i;
  assign start    = (state_q == ST_IDLE) && cmd_valid_i && out_free;
  assign last_col = (cur_x_q == COL_W'(COLUMNS - 1));
  assign last_row = (cur_y_q == ROW_W'(ROWS - 1));
  assign cur_addr = ADDR_W'(cur_y_q) * ADDR_W'(COLUMNS) + ADDR_W'(cur_x_q);
  assign cmd_addr = ADDR_W'(cmd_i.row) * ADDR_W'(COLUMNS) + ADDR_W'(cmd_i.col);
  assign blank    = {bg_q, fg_q, SPACE_CODE};

  assign busy_o      = (state_q == ST_INIT);
  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_INIT: begin
        if (cnt_q == ADDR_W'(CELL_COUNT - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          case (cmd_i.op)
            OP_PUT, OP_NEWLINE: begin
              if ((last_col || cmd_i.op == OP_NEWLINE) && last_row) state_d = ST_SCROLL;
            end
            OP_CLEAR: state_d = ST_BLANK;
            OP_READ:  state_d = ST_FINISH;
            default:  state_d = ST_IDLE;
          endcase
        end
      end
      ST_SCROLL: begin
        if (cnt_q == ADDR_W'(MOVE_COUNT)) state_d = ST_BLANK;
      end
      ST_BLANK: begin
        if (cnt_q == ADDR_W'(CELL_COUNT - 1)) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    cnt_d       = cnt_q;
    cur_x_d     = cur_x_q;
    cur_y_d     = cur_y_q;
    scr_d       = scr_q;
    rdf_d       = rdf_q;
    cmd_pop_o   = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = cnt_q;
    ram_wdata   = blank;
    ram_re      = 1'b0;
    ram_raddr   = cnt_q + ADDR_W'(COLUMNS);
    out_valid_d = out_valid_q && !res_ready_i;
    out_d       = out_q;

    case (state_q)
      ST_INIT: begin
        ram_we    = 1'b1;
        ram_wdata = RESET_CELL;
        cnt_d     = (cnt_q == ADDR_W'(CELL_COUNT - 1)) ? '0 : cnt_q + 1'b1;
      end
      ST_IDLE: begin
        if (start) begin
          cmd_pop_o = 1'b1;
          scr_d     = 1'b0;
          rdf_d     = 1'b0;
          cnt_d     = '0;
          case (cmd_i.op)
            OP_PUT, OP_NEWLINE: begin
              if (cmd_i.op == OP_PUT) begin
                ram_we    = 1'b1;
                ram_waddr = cur_addr;
                ram_wdata = {bg_q, fg_q, cmd_i.ch};
              end
              if (last_col || cmd_i.op == OP_NEWLINE) begin
                cur_x_d = '0;
                if (last_row) begin
                  scr_d = 1'b1;
                end else begin
                  cur_y_d = cur_y_q + 1'b1;
                end
              end else begin
                cur_x_d = cur_x_q + 1'b1;
              end
            end
            OP_CLEAR: begin
              cur_x_d = '0;
              cur_y_d = '0;
            end
            OP_SET: begin
              cur_x_d = cmd_i.col;
              cur_y_d = cmd_i.row;
            end
            OP_READ: begin
              ram_re    = 1'b1;
              ram_raddr = cmd_addr;
              rdf_d     = 1'b1;
            end
            default: begin
              rdf_d = 1'b0;
            end
          endcase
          // Single-step commands report right away.
          if ((cmd_i.op == OP_SET) ||
              ((cmd_i.op == OP_PUT || cmd_i.op == OP_NEWLINE) && !scr_d)) begin
            out_valid_d = 1'b1;
            out_d       = '{scrolled: 1'b0, cell_data: '0, row: cur_y_d, col: cur_x_d};
          end
        end
      end
      ST_SCROLL: begin
        // Read one row ahead while writing back the cell read last cycle.
        ram_re    = (cnt_q != ADDR_W'(MOVE_COUNT));
        ram_we    = (cnt_q != '0);
        ram_waddr = cnt_q - 1'b1;
        ram_wdata = ram_rdata;
        cnt_d     = cnt_q + 1'b1;
        if (cnt_q == ADDR_W'(MOVE_COUNT)) cnt_d = ADDR_W'(MOVE_COUNT);
      end
      ST_BLANK: begin
        ram_we = 1'b1;
        cnt_d  = cnt_q + 1'b1;
      end
      ST_FINISH: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = '{scrolled: scr_q,
                          cell_data: rdf_q ? ram_rdata : '0,
                          row: cur_y_q,
                          col: cur_x_q};
        end
      end
      default: begin
        cnt_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      cnt_q       <= '0;
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      scr_q       <= 1'b0;
      rdf_q       <= 1'b0;
      fg_q        <= COLOR_W'(8);
      bg_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      cur_x_q     <= cur_x_d;
      cur_y_q     <= cur_y_d;
      scr_q       <= scr_d;
      rdf_q       <= rdf_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i && cfg_idx_i == REG_FG) fg_q <= cfg_wdata_i;
      if (cfg_we_i && cfg_idx_i == REG_BG) bg_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELL_COUNT)
  ) u_screen (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

`default_nettype wire

FILE: rtl/text_console_writer_core.sv
// ----------------------------------------------------------------------------
// text_console_writer_core: character-cell text console with scrolling
// Keeps a COLUMNS x ROWS screen of 16-bit cells and a cursor; puts
// characters, clears, moves the cursor and reads back cells.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                    Payload
//  s_axis    in         s_axis_tvalid/s_axis_tready  tdata char/col/row, tuser mode
//  m_axis    out        m_axis_tvalid/m_axis_tready  tdata cursor, cell, scrolled
//  cfg       in         cfg_we_i                     cfg_idx_i, cfg_wdata_i
//
// Every input beat yields exactly one result beat. Put character, newline
// and set cursor complete in the idle state of the execution stage, so
// they sustain one beat per cycle while the result stream is ready; a
// cell read passes through the finish state because the screen RAM read
// is registered. A clear holds the execution stage while it writes one
// blank per cell and then issues the result. A put or newline that runs
// past the last row also moves the rows up through the registered read,
// blanks the bottom row and then issues the result. After reset a
// clearing pass fills all CELL_COUNT cells (2000 at 80 x 25) with blanks;
// no beat is accepted then, while configuration writes are taken. The
// two-entry command queue lets input keep flowing while the execution
// stage waits on a stalled output.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_writer_core (
  input  wire                           clk_i,
  input  wire                           rst_ni,

  // Input stream.
  input  wire                           s_axis_tvalid,
  output logic                          s_axis_tready,
  input  wire  [23:0]                   s_axis_tdata,  // char_code[7:0], col[15:8], row[23:16]
  input  wire  [tcw_pkg::MODE_W-1:0]    s_axis_tuser,  // mode[1:0]

  // Result stream.
  output logic                          m_axis_tvalid,
  input  wire                           m_axis_tready,
  output logic [31:0]                   m_axis_tdata,  // cursor_col[6:0], cursor_row[11:7],
                                                       // cell_data[27:12], scrolled[28]

  // Configuration writes.
  input  wire                           cfg_we_i,
  input  wire  [tcw_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire  [tcw_pkg::COLOR_W-1:0]   cfg_wdata_i
);
  import tcw_pkg::*;

  logic busy;
  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;
  res_t res;

  // The front end decodes each beat into a command with clamped
  // coordinates; the back end pops commands when its result slot is free.
  tcw_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .busy_i        (busy),
    .cmd_valid_o   (cmd_valid),
    .cmd_o         (cmd),
    .cmd_pop_i     (cmd_pop)
  );

  tcw_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .busy_o      (busy),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  // The result struct already packs its last field in the lowest bits.
  assign m_axis_tdata = {(32 - $bits(res_t))'(0), res};

endmodule

`default_nettype wire
